// ===== src/vfv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared constants for the voxel face visibility block: chunk geometry,
// field widths and operation codes.
// ----------------------------------------------------------------------------
package vfv_pkg;

  localparam int COORD_W    = 5;
  localparam int CHUNK_SIZE = 1 << COORD_W;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int VALUE_W    = 16;
  localparam int MASK_W     = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CHUNK_SIZE-1:0] column_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [MASK_W-1:0]     mask_t;

endpackage
`default_nettype wire

// ===== src/vfv_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_if
// Valid/ready channels: voxel command words in, face mask words out.
// ----------------------------------------------------------------------------
interface vfv_in_if;
  logic            valid;
  logic            ready;
  logic            operation;
  vfv_pkg::coord_t coord_a;
  vfv_pkg::coord_t coord_b;
  vfv_pkg::coord_t coord_c;
  vfv_pkg::value_t block_value;

  modport source (output valid, output operation, output coord_a, output coord_b,
                  output coord_c, output block_value, input ready);
  modport sink   (input valid, input operation, input coord_a, input coord_b,
                  input coord_c, input block_value, output ready);
endinterface

interface vfv_out_if;
  logic           valid;
  logic           ready;
  vfv_pkg::mask_t face_mask;

  modport source (output valid, output face_mask, input ready);
  modport sink   (input valid, input face_mask, output ready);
endinterface
`default_nettype wire

// ===== src/voxel_face_visibility_mask.sv =====
`default_nettype none
// Query path: an accepted query is read into the read registers and its face mask loaded
// into the output register in the read state, which waits while that register holds an
// unaccepted mask. No word is taken before the last leaves the read state, set by the read
// then write-back on each column store's single port (one row per store per word).
// Reset: a clearing pass sweeps all 1024 rows of the three stores, one row a cycle, and no
// word is accepted until it ends.
// ----------------------------------------------------------------------------
// voxel_face_visibility_mask
// Keeps a 32x32x32 solid/empty chunk as three column bit stores (along c, b, a)
// and answers face visibility queries from one row of each store.
// ----------------------------------------------------------------------------
module voxel_face_visibility_mask (
  input  wire logic clk,
  input  wire logic rst_n,
  vfv_in_if.sink    in_chan,
  vfv_out_if.source out_chan
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  vfv_pkg::addr_t   clr_cnt_r, clr_cnt_nxt;

  // column stores
  vfv_pkg::column_t mem_c [vfv_pkg::DEPTH];
  vfv_pkg::column_t mem_b [vfv_pkg::DEPTH];
  vfv_pkg::column_t mem_a [vfv_pkg::DEPTH];
  vfv_pkg::column_t rd_c_r, rd_b_r, rd_a_r;

  // captured word
  logic             op_r;
  logic             solid_r;
  vfv_pkg::coord_t  a_r, b_r, c_r;

  logic             out_valid_r, out_valid_nxt;
  vfv_pkg::mask_t   mask_r;

  logic             accept;
  logic             we;
  logic             load_out;
  vfv_pkg::addr_t   wa_c, wa_b, wa_a;
  vfv_pkg::addr_t   ra_c, ra_b, ra_a;
  vfv_pkg::column_t wd_c, wd_b, wd_a;
  vfv_pkg::column_t plus_c, minus_c, plus_b, minus_b, plus_a, minus_a;
  vfv_pkg::mask_t   mask_nxt;

  assign in_chan.ready      = (state_r == S_IDLE);
  assign accept             = in_chan.valid && in_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.face_mask = mask_r;

  assign ra_c = {in_chan.coord_a, in_chan.coord_b};
  assign ra_b = {in_chan.coord_a, in_chan.coord_c};
  assign ra_a = {in_chan.coord_b, in_chan.coord_c};

  // a bit is a + face when the next bit up is clear, a - face when the one below is
  assign plus_c  = rd_c_r & ~(rd_c_r >> 1);
  assign minus_c = rd_c_r & ~(rd_c_r << 1);
  assign plus_b  = rd_b_r & ~(rd_b_r >> 1);
  assign minus_b = rd_b_r & ~(rd_b_r << 1);
  assign plus_a  = rd_a_r & ~(rd_a_r >> 1);
  assign minus_a = rd_a_r & ~(rd_a_r << 1);

  assign mask_nxt = {plus_c[c_r], minus_c[c_r], plus_b[b_r], minus_b[b_r],
                     plus_a[a_r], minus_a[a_r]};

  assign load_out = (state_r == S_READ) && (op_r == vfv_pkg::OP_QUERY)
                    && (!out_valid_r || out_chan.ready);

  always_comb begin
    we   = 1'b0;
    wa_c = clr_cnt_r;
    wa_b = clr_cnt_r;
    wa_a = clr_cnt_r;
    wd_c = '0;
    wd_b = '0;
    wd_a = '0;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
    end else if (state_r == S_READ && op_r == vfv_pkg::OP_WRITE) begin
      we   = 1'b1;
      wa_c = {a_r, b_r};
      wa_b = {a_r, c_r};
      wa_a = {b_r, c_r};
      if (solid_r) begin
        wd_c = rd_c_r | (vfv_pkg::column_t'(1) << c_r);
        wd_b = rd_b_r | (vfv_pkg::column_t'(1) << b_r);
        wd_a = rd_a_r | (vfv_pkg::column_t'(1) << a_r);
      end else begin
        wd_c = rd_c_r & ~(vfv_pkg::column_t'(1) << c_r);
        wd_b = rd_b_r & ~(vfv_pkg::column_t'(1) << b_r);
        wd_a = rd_a_r & ~(vfv_pkg::column_t'(1) << a_r);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + vfv_pkg::addr_t'(1);
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        // hold a query until the output register is free
        if (op_r == vfv_pkg::OP_WRITE || load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_chan.operation;
      solid_r <= (in_chan.block_value != '0);
      a_r     <= in_chan.coord_a;
      b_r     <= in_chan.coord_b;
      c_r     <= in_chan.coord_c;
    end
    if (load_out) mask_r <= mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_c[wa_c] <= wd_c;
      mem_b[wa_b] <= wd_b;
      mem_a[wa_a] <= wd_a;
    end
    if (accept) begin
      rd_c_r <= mem_c[ra_c];
      rd_b_r <= mem_b[ra_b];
      rd_a_r <= mem_a[ra_a];
    end
  end

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_chan.ready)
    else $error("input accepted during clearing pass");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_READ))
    else $error("accepted word did not enter read state");

  a_query_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("query result not presented");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && op_r == vfv_pkg::OP_WRITE && !out_valid_r) |=> !out_valid_r)
    else $error("write produced a result");
`endif

endmodule
`default_nettype wire
